// File: rtl/core/wrst_pkg.sv
package wrst_pkg;

    // Beat field widths
    localparam int MODE_W     = 3;
    localparam int ID_W       = 8;
    localparam int WEIGHT_W   = 16;
    localparam int FRAC_W     = 16;
    localparam int STATUS_W   = 3;
    localparam int COUNT_W    = 7;
    localparam int TOTAL_W    = 22;
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 40;

    typedef enum logic [MODE_W-1:0] {
        MODE_REGISTER      = 3'd0,
        MODE_MARK_FULL     = 3'd1,
        MODE_MARK_AVAIL    = 3'd2,
        MODE_WEIGHTED_PICK = 3'd3,
        MODE_UNIFORM_PICK  = 3'd4
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 3'd0,
        STATUS_DUP   = 3'd1,
        STATUS_NONE  = 3'd2,
        STATUS_FULL  = 3'd3,
        STATUS_AVAIL = 3'd4
    } status_t;

endpackage

// File: rtl/core/weighted_random_selector_table_top.sv
// Weighted random selector table.
// Input stream (s_axis_*): one beat is one operation, the mode travels in tuser:
// register an id with a weight, mark an id full (ordered removal from the
// available list), mark it available again (append), weighted roulette pick or
// uniform pick. Output stream (m_axis_*): exactly one result beat per input
// beat, in order, carrying status in tuser and picked id, list length and
// weight total in tdata.
// Path of a beat: taken in S_IDLE, decided in S_DECIDE, loaded into the output
// register from S_DONE; uniform pick reads the list in S_UREAD and S_UDATA, and
// mark full and weighted pick walk the list in S_WALK: one list read per cycle,
// then, for a weighted pick, a dependent entry-table read for the weight; the
// walk grows with avail_count. One item is worked at a time; the next beat is
// taken in the cycle after the result is loaded into the output register.
// Reset: an entry-table clearing pass runs for ID_COUNT cycles after rst_n
// rises; s_axis_tready stays low during it. List length and total reset to 0.
// Stall: a result waits in the output register while m_axis_tready is low; the
// next beat is accepted meanwhile and its result is held until the slot frees.
module weighted_random_selector_table_top #(
    parameter int MAX_AVAILABLE = 64,
    parameter int ID_COUNT      = 256,
    parameter int WEIGHT_BITS   = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // entry_id [7:0], entry_weight [23:8], rand_fraction [39:24]
    input  logic [wrst_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // mode [2:0]
    input  logic [wrst_pkg::MODE_W-1:0]    s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // picked_id [7:0], avail_count [14:8], weight_total [36:15], zero [39:37]
    output logic [wrst_pkg::M_TDATA_W-1:0] m_axis_tdata,
    // status [2:0]
    output logic [wrst_pkg::STATUS_W-1:0]  m_axis_tuser
);

    localparam int ID_BITS  = $clog2(ID_COUNT);
    localparam int IDX_BITS = $clog2(MAX_AVAILABLE);
    localparam int CNT_BITS = $clog2(MAX_AVAILABLE + 1);
    localparam int SUM_BITS = WEIGHT_BITS + CNT_BITS;
    localparam int FW       = wrst_pkg::FRAC_W;
    localparam int PAD_W    = wrst_pkg::M_TDATA_W - wrst_pkg::TOTAL_W
                              - wrst_pkg::COUNT_W - wrst_pkg::ID_W;

    typedef enum logic [6:0] {
        S_CLEAR  = 7'b0000001,
        S_IDLE   = 7'b0000010,
        S_DECIDE = 7'b0000100,
        S_WALK   = 7'b0001000,
        S_UREAD  = 7'b0010000,
        S_UDATA  = 7'b0100000,
        S_DONE   = 7'b1000000
    } state_t;

    typedef struct packed {
        logic                   registered;
        logic                   listed;
        logic [WEIGHT_BITS-1:0] weight;
    } id_entry_t;

    // Memories
    id_entry_t           id_mem [ID_COUNT];
    logic [ID_BITS-1:0]  list_mem [MAX_AVAILABLE];
    id_entry_t           id_rd_data;
    logic [ID_BITS-1:0]  list_rd_data;

    logic                id_we;
    logic [ID_BITS-1:0]  id_waddr;
    id_entry_t           id_wdata;
    logic [ID_BITS-1:0]  id_raddr;
    logic                list_we;
    logic [IDX_BITS-1:0] list_waddr;
    logic [ID_BITS-1:0]  list_wdata;
    logic [IDX_BITS-1:0] list_raddr;

    // Control state
    state_t              state_reg, state_next;
    logic [ID_BITS-1:0]  clr_idx_reg, clr_idx_next;
    logic [CNT_BITS-1:0] len_reg, len_next;
    logic [SUM_BITS-1:0] sum_reg, sum_next;
    logic                m_valid_reg, m_valid_next;
    logic                a_valid_reg, a_valid_next;
    logic                b_valid_reg, b_valid_next;

    // Item payload and walk state
    wrst_pkg::mode_t     mode_reg, mode_next;
    logic [ID_BITS-1:0]  id_idx_reg, id_idx_next;
    logic                id_ok_reg, id_ok_next;
    logic [WEIGHT_BITS-1:0] weight_in_reg, weight_in_next;
    logic [FW-1:0]       frac_reg, frac_next;
    wrst_pkg::status_t   status_reg, status_next;
    logic [ID_BITS-1:0]  picked_reg, picked_next;
    logic [SUM_BITS+FW-1:0] target_reg, target_next;
    logic [IDX_BITS-1:0] uidx_reg, uidx_next;
    logic [CNT_BITS-1:0] rd_cnt_reg, rd_cnt_next;
    logic [IDX_BITS-1:0] a_idx_reg, a_idx_next;
    logic [ID_BITS-1:0]  b_id_reg, b_id_next;
    logic                b_first_reg, b_first_next;
    logic [SUM_BITS-1:0] accum_reg, accum_next;
    logic                found_reg, found_next;
    logic [wrst_pkg::M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    wrst_pkg::status_t   m_tuser_reg, m_tuser_next;

    logic [wrst_pkg::ID_W-1:0] in_id;
    logic [CNT_BITS+FW-1:0] uprod;
    logic [CNT_BITS-1:0] uq;
    logic [SUM_BITS+FW-1:0] tprod;
    logic                walk_done;

    assign in_id = s_axis_tdata[7:0];
    assign uprod = (CNT_BITS+FW)'(len_reg) * (CNT_BITS+FW)'(frac_reg);
    assign uq    = uprod[CNT_BITS+FW-1:FW];
    assign tprod = (SUM_BITS+FW)'(sum_reg) * (SUM_BITS+FW)'(frac_reg);
    assign walk_done = (rd_cnt_reg == len_reg) && !a_valid_reg && !b_valid_reg;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_tdata_reg;
    assign m_axis_tuser  = m_tuser_reg;

    // The entry table is read at the incoming id on acceptance, else at the
    // id just returned by the list during a weighted walk.
    assign id_raddr   = (state_reg == S_IDLE) ? ID_BITS'(in_id) : list_rd_data;
    assign list_raddr = (state_reg == S_UREAD) ? uidx_reg : IDX_BITS'(rd_cnt_reg);

    always_ff @(posedge clk)
    begin
        if (id_we)
        begin
            id_mem[id_waddr] <= id_wdata;
        end
        id_rd_data <= id_mem[id_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (list_we)
        begin
            list_mem[list_waddr] <= list_wdata;
        end
        list_rd_data <= list_mem[list_raddr];
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_idx_next   = clr_idx_reg;
        len_next       = len_reg;
        sum_next       = sum_reg;
        m_valid_next   = m_valid_reg;
        a_valid_next   = a_valid_reg;
        b_valid_next   = b_valid_reg;
        mode_next      = mode_reg;
        id_idx_next    = id_idx_reg;
        id_ok_next     = id_ok_reg;
        weight_in_next = weight_in_reg;
        frac_next      = frac_reg;
        status_next    = status_reg;
        picked_next    = picked_reg;
        target_next    = target_reg;
        uidx_next      = uidx_reg;
        rd_cnt_next    = rd_cnt_reg;
        a_idx_next     = a_idx_reg;
        b_id_next      = b_id_reg;
        b_first_next   = b_first_reg;
        accum_next     = accum_reg;
        found_next     = found_reg;
        m_tdata_next   = m_tdata_reg;
        m_tuser_next   = m_tuser_reg;

        id_we      = 1'b0;
        id_waddr   = id_idx_reg;
        id_wdata   = '0;
        list_we    = 1'b0;
        list_waddr = IDX_BITS'(len_reg);
        list_wdata = id_idx_reg;

        // Release the output slot when the receiver takes the beat
        if (m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                id_we    = 1'b1;
                id_waddr = clr_idx_reg;
                id_wdata = '0;
                if (clr_idx_reg == ID_BITS'(ID_COUNT - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_idx_next = clr_idx_reg + ID_BITS'(1);
                end
            end

            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    mode_next      = wrst_pkg::mode_t'(s_axis_tuser);
                    id_idx_next    = ID_BITS'(in_id);
                    id_ok_next     = 32'(in_id) < 32'(ID_COUNT);
                    weight_in_next = WEIGHT_BITS'(s_axis_tdata[23:8]);
                    frac_next      = s_axis_tdata[39:24];
                    status_next    = wrst_pkg::STATUS_OK;
                    picked_next    = '0;
                    state_next     = S_DECIDE;
                end
            end

            S_DECIDE:
            begin
                state_next   = S_DONE;
                rd_cnt_next  = '0;
                accum_next   = '0;
                found_next   = 1'b0;
                a_valid_next = 1'b0;
                b_valid_next = 1'b0;
                target_next  = tprod;
                uidx_next    = (uq >= len_reg) ? IDX_BITS'(len_reg - CNT_BITS'(1))
                                               : IDX_BITS'(uq);
                case (mode_reg)
                    wrst_pkg::MODE_REGISTER:
                    begin
                        if (!id_ok_reg)
                        begin
                            status_next = wrst_pkg::STATUS_NONE;
                        end
                        else if (id_rd_data.registered)
                        begin
                            status_next = wrst_pkg::STATUS_DUP;
                        end
                        else if (len_reg >= CNT_BITS'(MAX_AVAILABLE))
                        begin
                            status_next = wrst_pkg::STATUS_FULL;
                        end
                        else
                        begin
                            id_we    = 1'b1;
                            id_wdata = '{registered: 1'b1, listed: 1'b1,
                                         weight: weight_in_reg};
                            list_we  = 1'b1;
                            len_next = len_reg + CNT_BITS'(1);
                            sum_next = sum_reg + SUM_BITS'(weight_in_reg);
                        end
                    end

                    wrst_pkg::MODE_MARK_FULL:
                    begin
                        if (!id_ok_reg || !id_rd_data.listed)
                        begin
                            status_next = wrst_pkg::STATUS_NONE;
                        end
                        else
                        begin
                            // Drop the weight now; the walk closes the gap
                            id_we      = 1'b1;
                            id_wdata   = '{registered: 1'b1, listed: 1'b0,
                                           weight: id_rd_data.weight};
                            sum_next   = sum_reg - SUM_BITS'(id_rd_data.weight);
                            state_next = S_WALK;
                        end
                    end

                    wrst_pkg::MODE_MARK_AVAIL:
                    begin
                        if (!id_ok_reg || !id_rd_data.registered)
                        begin
                            status_next = wrst_pkg::STATUS_NONE;
                        end
                        else if (id_rd_data.listed)
                        begin
                            status_next = wrst_pkg::STATUS_AVAIL;
                        end
                        else if (len_reg >= CNT_BITS'(MAX_AVAILABLE))
                        begin
                            status_next = wrst_pkg::STATUS_FULL;
                        end
                        else
                        begin
                            id_we    = 1'b1;
                            id_wdata = '{registered: 1'b1, listed: 1'b1,
                                         weight: id_rd_data.weight};
                            list_we  = 1'b1;
                            len_next = len_reg + CNT_BITS'(1);
                            sum_next = sum_reg + SUM_BITS'(id_rd_data.weight);
                        end
                    end

                    wrst_pkg::MODE_WEIGHTED_PICK:
                    begin
                        if (len_reg == '0)
                        begin
                            status_next = wrst_pkg::STATUS_NONE;
                        end
                        else
                        begin
                            state_next = S_WALK;
                        end
                    end

                    wrst_pkg::MODE_UNIFORM_PICK:
                    begin
                        if (len_reg == '0)
                        begin
                            status_next = wrst_pkg::STATUS_NONE;
                        end
                        else
                        begin
                            state_next = S_UREAD;
                        end
                    end

                    default:
                    begin
                        status_next = wrst_pkg::STATUS_OK;
                    end
                endcase
            end

            S_WALK:
            begin
                a_valid_next = 1'b0;
                b_valid_next = 1'b0;
                // Issue one list read per cycle
                if (rd_cnt_reg < len_reg)
                begin
                    a_valid_next = 1'b1;
                    a_idx_next   = IDX_BITS'(rd_cnt_reg);
                    rd_cnt_next  = rd_cnt_reg + CNT_BITS'(1);
                end
                // List entry returned
                if (a_valid_reg)
                begin
                    if (mode_reg == wrst_pkg::MODE_WEIGHTED_PICK)
                    begin
                        b_valid_next = 1'b1;
                        b_id_next    = list_rd_data;
                        b_first_next = (a_idx_reg == '0);
                    end
                    else if (found_reg)
                    begin
                        // Shift every entry behind the removed one down by one
                        list_we    = 1'b1;
                        list_waddr = a_idx_reg - IDX_BITS'(1);
                        list_wdata = list_rd_data;
                    end
                    else if (list_rd_data == id_idx_reg)
                    begin
                        found_next = 1'b1;
                    end
                end
                // Weight returned: advance the wheel while the sum stays at or
                // below the target; once it passes, accum freezes and so does
                // the outcome of the compare.
                if (b_valid_reg)
                begin
                    if (b_first_reg || !({accum_reg, FW'(0)} > target_reg))
                    begin
                        picked_next = b_id_reg;
                        accum_next  = accum_reg + SUM_BITS'(id_rd_data.weight);
                    end
                end
                if (walk_done)
                begin
                    if (mode_reg == wrst_pkg::MODE_MARK_FULL)
                    begin
                        len_next = len_reg - CNT_BITS'(1);
                    end
                    state_next = S_DONE;
                end
            end

            S_UREAD:
            begin
                state_next = S_UDATA;
            end

            S_UDATA:
            begin
                picked_next = list_rd_data;
                state_next  = S_DONE;
            end

            S_DONE:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    m_valid_next = 1'b1;
                    m_tdata_next = {PAD_W'(0),
                                    wrst_pkg::TOTAL_W'(sum_reg),
                                    wrst_pkg::COUNT_W'(len_reg),
                                    wrst_pkg::ID_W'(picked_reg)};
                    m_tuser_next = status_reg;
                    state_next   = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_idx_reg <= '0;
            len_reg     <= '0;
            sum_reg     <= '0;
            m_valid_reg <= 1'b0;
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_idx_reg <= clr_idx_next;
            len_reg     <= len_next;
            sum_reg     <= sum_next;
            m_valid_reg <= m_valid_next;
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg      <= mode_next;
        id_idx_reg    <= id_idx_next;
        id_ok_reg     <= id_ok_next;
        weight_in_reg <= weight_in_next;
        frac_reg      <= frac_next;
        status_reg    <= status_next;
        picked_reg    <= picked_next;
        target_reg    <= target_next;
        uidx_reg      <= uidx_next;
        rd_cnt_reg    <= rd_cnt_next;
        a_idx_reg     <= a_idx_next;
        b_id_reg      <= b_id_next;
        b_first_reg   <= b_first_next;
        accum_reg     <= accum_next;
        found_reg     <= found_next;
        m_tdata_reg   <= m_tdata_next;
        m_tuser_reg   <= m_tuser_next;
    end

`ifndef SYNTHESIS
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= CNT_BITS'(MAX_AVAILABLE))
        else $error("available list length beyond capacity");

    a_empty_total: assert property (@(posedge clk) disable iff (!rst_n)
        (len_reg == '0) |-> (sum_reg == '0))
        else $error("empty list with nonzero weight total");

    a_remove_found: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK && walk_done && mode_reg == wrst_pkg::MODE_MARK_FULL)
        |-> found_reg)
        else $error("listed id not found in available list");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(state_reg == S_DONE))
        else $error("result beat raised outside completion");
`endif

endmodule

// File: tb/weighted_random_selector_table_top_tb.sv
`timescale 1ns / 1ps

module weighted_random_selector_table_top_tb;

    import wrst_pkg::*;

    localparam int     CLK_PERIOD    = 8;
    localparam int     RESET_CYCLES  = 11;
    localparam int     LIST_CAP      = 64;
    localparam int     ID_SPAN       = 256;
    localparam int     PHASE_ITEMS   = 250;
    localparam int     DRAIN_CYCLES  = 80;    // longest walk is at a full list
    localparam int     REPORT_LIMIT  = 10;
    localparam longint TIMEOUT_NS    = 8_000_000;

    // Modes the block accepts but ignores
    localparam logic [MODE_W-1:0] MODE_UNUSED_FIRST = 3'd5;
    localparam logic [MODE_W-1:0] MODE_UNUSED_LAST  = 3'd7;

    localparam logic [15:0] W_MAX = 16'hFFFF;
    localparam logic [15:0] F_MAX = 16'hFFFF;

    typedef struct packed {
        status_t     status;
        logic [7:0]  picked;
        logic [6:0]  count;
        logic [21:0] total;
    } sel_result_t;

    typedef struct packed {
        logic [MODE_W-1:0] op;
        logic [7:0]        id;
        logic [15:0]       weight;
        logic [15:0]       frac;
        bit                known;   // result typed in below, otherwise predicted
        status_t           st;
        logic [7:0]        picked;
        logic [6:0]        count;
        logic [21:0]       total;
    } step_row_t;

    localparam int ROW_COUNT = 24;

    // Directed opening: empty-list picks, unknown ids, unused modes, the weight
    // extremes, duplicates, re-listing, zero totals and zero leading weights.
    step_row_t directed_rows [ROW_COUNT] = '{
        '{MODE_WEIGHTED_PICK, 8'd0,   16'd0,  16'd0,   1'b1, STATUS_NONE,  8'd0, 7'd0, 22'd0},
        '{MODE_UNIFORM_PICK,  8'd0,   16'd0,  F_MAX,   1'b1, STATUS_NONE,  8'd0, 7'd0, 22'd0},
        '{MODE_MARK_FULL,     8'd5,   16'd0,  16'd0,   1'b1, STATUS_NONE,  8'd0, 7'd0, 22'd0},
        '{MODE_MARK_AVAIL,    8'd5,   16'd0,  16'd0,   1'b1, STATUS_NONE,  8'd0, 7'd0, 22'd0},
        '{MODE_UNUSED_FIRST,  8'hFF,  W_MAX,  F_MAX,   1'b1, STATUS_OK,    8'd0, 7'd0, 22'd0},
        '{MODE_REGISTER,      8'd0,   W_MAX,  16'd0,   1'b1, STATUS_OK,    8'd0, 7'd1, 22'hFFFF},
        '{MODE_REGISTER,      8'hFF,  16'd0,  F_MAX,   1'b1, STATUS_OK,    8'd0, 7'd2, 22'hFFFF},
        '{MODE_REGISTER,      8'd0,   16'h1234, 16'd0, 1'b1, STATUS_DUP,   8'd0, 7'd2, 22'hFFFF},
        '{MODE_MARK_AVAIL,    8'd0,   16'd0,  16'd0,   1'b1, STATUS_AVAIL, 8'd0, 7'd2, 22'hFFFF},
        '{MODE_WEIGHTED_PICK, 8'd0,   16'd0,  16'd0,   1'b1, STATUS_OK,    8'd0, 7'd2, 22'hFFFF},
        '{MODE_WEIGHTED_PICK, 8'd0,   16'd0,  F_MAX,   1'b0, STATUS_OK,    8'd0, 7'd0, 22'd0},
        '{MODE_UNIFORM_PICK,  8'd0,   16'd0,  16'd0,   1'b1, STATUS_OK,    8'd0, 7'd2, 22'hFFFF},
        '{MODE_UNIFORM_PICK,  8'd0,   16'd0,  F_MAX,   1'b0, STATUS_OK,    8'd0, 7'd0, 22'd0},
        '{MODE_MARK_FULL,     8'd0,   16'd0,  16'd0,   1'b1, STATUS_OK,    8'd0, 7'd1, 22'd0},
        '{MODE_MARK_FULL,     8'd0,   16'd0,  16'd0,   1'b1, STATUS_NONE,  8'd0, 7'd1, 22'd0},
        '{MODE_WEIGHTED_PICK, 8'd0,   16'd0,  16'h8000, 1'b0, STATUS_OK,   8'd0, 7'd0, 22'd0},
        '{MODE_MARK_AVAIL,    8'd0,   16'd0,  16'd0,   1'b1, STATUS_OK,    8'd0, 7'd2, 22'hFFFF},
        '{MODE_WEIGHTED_PICK, 8'd0,   16'd0,  16'd0,   1'b0, STATUS_OK,    8'd0, 7'd0, 22'd0},
        '{MODE_REGISTER,      8'd7,   16'h0100, 16'd0, 1'b0, STATUS_OK,    8'd0, 7'd0, 22'd0},
        '{MODE_UNIFORM_PICK,  8'd0,   16'd0,  16'hAAAA, 1'b0, STATUS_OK,   8'd0, 7'd0, 22'd0},
        '{MODE_MARK_FULL,     8'hFF,  16'd0,  16'd0,   1'b0, STATUS_OK,    8'd0, 7'd0, 22'd0},
        '{MODE_WEIGHTED_PICK, 8'd0,   16'd0,  16'h5555, 1'b0, STATUS_OK,   8'd0, 7'd0, 22'd0},
        '{MODE_UNUSED_LAST,   8'h5A,  16'hA5A5, 16'h5A5A, 1'b0, STATUS_OK, 8'd0, 7'd0, 22'd0},
        '{MODE_MARK_FULL,     8'd1,   16'd0,  16'd0,   1'b0, STATUS_OK,    8'd0, 7'd0, 22'd0}
    };

    // Idle percentages per phase: none, sender, receiver, both
    int send_pcts [4] = '{0, 72, 0, 37};
    int recv_pcts [4] = '{0, 0, 72, 37};

    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [S_TDATA_W-1:0]   s_axis_tdata  = '0;
    logic [MODE_W-1:0]      s_axis_tuser  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_axis_tdata;
    logic [STATUS_W-1:0]    m_axis_tuser;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int error_count    = 0;

    // Shadow of the selector state
    bit          is_registered [ID_SPAN];
    logic [15:0] weight_of     [ID_SPAN];
    logic [7:0]  avail_ids     [$];
    logic [21:0] weight_sum    = '0;
    bit          filling       = 1'b1;

    sel_result_t expected_results [$];

    weighted_random_selector_table_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Position of an id in the available list, -1 when absent
    function automatic int list_pos(logic [7:0] id);
        for (int i = 0; i < avail_ids.size(); i++)
            if (avail_ids[i] == id)
                return i;
        return -1;
    endfunction

    // Apply one operation to the shadow state and return the result it yields
    function automatic sel_result_t apply_selector_op(logic [MODE_W-1:0] op, logic [7:0] id,
                                                      logic [15:0] w, logic [15:0] frac);
        sel_result_t       res;
        int                pos;
        longint unsigned   target;
        longint unsigned   accum;
        longint unsigned   slot;
        res.status = STATUS_OK;
        res.picked = '0;
        case (op)
            MODE_REGISTER:
                if (is_registered[id])
                    res.status = STATUS_DUP;
                else if (avail_ids.size() >= LIST_CAP)
                    res.status = STATUS_FULL;
                else
                begin
                    is_registered[id] = 1'b1;
                    weight_of[id] = w;
                    avail_ids = {avail_ids, id};
                    weight_sum += 22'(w);
                end
            MODE_MARK_FULL:
            begin
                pos = list_pos(id);
                if (pos < 0)
                    res.status = STATUS_NONE;
                else
                begin
                    weight_sum -= 22'(weight_of[id]);
                    avail_ids.delete(pos);   // keeps the order of the rest
                end
            end
            MODE_MARK_AVAIL:
                if (!is_registered[id])
                    res.status = STATUS_NONE;
                else if (list_pos(id) >= 0)
                    res.status = STATUS_AVAIL;
                else if (avail_ids.size() >= LIST_CAP)
                    res.status = STATUS_FULL;
                else
                begin
                    avail_ids = {avail_ids, id};
                    weight_sum += 22'(weight_of[id]);
                end
            MODE_WEIGHTED_PICK:
                if (avail_ids.size() == 0)
                    res.status = STATUS_NONE;
                else
                begin
                    // Roulette walk with an exact Q22.0 x Q0.16 target
                    target = 64'(weight_sum);
                    target = target * 64'(frac);
                    res.picked = avail_ids[0];
                    accum = 64'(weight_of[avail_ids[0]]);
                    for (int i = 1; i < avail_ids.size(); i++)
                    begin
                        if ((accum << 16) > target)
                            break;
                        res.picked = avail_ids[i];
                        accum += 64'(weight_of[avail_ids[i]]);
                    end
                end
            MODE_UNIFORM_PICK:
                if (avail_ids.size() == 0)
                    res.status = STATUS_NONE;
                else
                begin
                    slot = 64'(avail_ids.size());
                    slot = (slot * 64'(frac)) >> 16;
                    if (slot >= 64'(avail_ids.size()))
                        slot = 64'(avail_ids.size() - 1);
                    res.picked = avail_ids[slot];
                end
            default: ;
        endcase
        res.count = 7'(avail_ids.size());
        res.total = weight_sum;
        return res;
    endfunction

    // Choose the next random operation; well-formed fill and drain sweeps
    // dominate so the list reaches both the empty and the full end.
    task automatic pick_random_op(output logic [MODE_W-1:0] op, output logic [7:0] id,
                                  output logic [15:0] w, output logic [15:0] frac);
        int roll;
        int tries;
        if (avail_ids.size() >= LIST_CAP && $urandom_range(0, 3) == 0)
            filling = 1'b0;
        else if (avail_ids.size() == 0 && $urandom_range(0, 3) == 0)
            filling = 1'b1;
        else if ($urandom_range(0, 99) < 2)
            filling = !filling;

        roll = $urandom_range(0, 99);
        if (filling)
        begin
            if (roll < 30)      op = MODE_REGISTER;
            else if (roll < 55) op = MODE_MARK_AVAIL;
            else if (roll < 65) op = MODE_MARK_FULL;
            else if (roll < 82) op = MODE_WEIGHTED_PICK;
            else if (roll < 97) op = MODE_UNIFORM_PICK;
            else                op = MODE_W'($urandom_range(MODE_UNUSED_FIRST, MODE_UNUSED_LAST));
        end
        else
        begin
            if (roll < 8)       op = MODE_REGISTER;
            else if (roll < 15) op = MODE_MARK_AVAIL;
            else if (roll < 55) op = MODE_MARK_FULL;
            else if (roll < 75) op = MODE_WEIGHTED_PICK;
            else if (roll < 95) op = MODE_UNIFORM_PICK;
            else                op = MODE_W'($urandom_range(MODE_UNUSED_FIRST, MODE_UNUSED_LAST));
        end

        id = 8'($urandom_range(0, ID_SPAN - 1));
        if (op == MODE_MARK_FULL && avail_ids.size() > 0 && $urandom_range(0, 3) != 0)
            id = avail_ids[$urandom_range(0, avail_ids.size() - 1)];
        else if (op == MODE_MARK_AVAIL && $urandom_range(0, 3) != 0)
        begin
            // Hunt for a registered id that is currently off the list
            tries = 0;
            while (tries < 16 && !(is_registered[id] && list_pos(id) < 0))
            begin
                id = 8'($urandom_range(0, ID_SPAN - 1));
                tries++;
            end
        end

        roll = $urandom_range(0, 9);
        w = (roll == 0) ? 16'd0 : (roll == 1) ? W_MAX : 16'($urandom_range(0, 65535));
        roll = $urandom_range(0, 9);
        frac = (roll == 0) ? 16'd0 : (roll == 1) ? F_MAX : 16'($urandom_range(0, 65535));
    endtask

    // Present one beat after a random hold-off and wait for the handshake
    task automatic offer_beat(logic [MODE_W-1:0] op, logic [7:0] id,
                              logic [15:0] w, logic [15:0] frac);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {frac, w, id};
        s_axis_tuser  <= op;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    task automatic report_failure(string what, sel_result_t want, sel_result_t got);
        error_count++;
        if (error_count <= REPORT_LIMIT)
            $display({"%s: exp status %0d id %0d count %0d total %0d, ",
                      "got status %0d id %0d count %0d total %0d"},
                     what, want.status, want.picked, want.count, want.total,
                     got.status, got.picked, got.count, got.total);
    endtask

    // Receiver: stall at random and check each result beat against the
    // oldest outstanding prediction.
    always @(posedge clk)
    begin : result_check
        sel_result_t got;
        sel_result_t want;
        m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.status = status_t'(m_axis_tuser);
            got.picked = m_axis_tdata[7:0];
            got.count  = m_axis_tdata[14:8];
            got.total  = m_axis_tdata[36:15];
            if (expected_results.size() == 0)
                report_failure("unexpected result", '0, got);
            else
            begin
                want = expected_results.pop_front();
                if (got !== want)
                    report_failure("mismatch", want, got);
            end
        end
    end

    initial
    begin : stimulus
        step_row_t         row;
        sel_result_t       res;
        logic [MODE_W-1:0] op;
        logic [7:0]        id;
        logic [15:0]       w;
        logic [15:0]       frac;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Directed rows, no idling
        foreach (directed_rows[r])
        begin
            row = directed_rows[r];
            offer_beat(row.op, row.id, row.weight, row.frac);
            res = apply_selector_op(row.op, row.id, row.weight, row.frac);
            if (row.known)
                res = '{row.st, row.picked, row.count, row.total};
            expected_results = {expected_results, res};
        end

        // Random sweeps, one idling pattern per phase
        for (int p = 0; p < 4; p++)
        begin
            send_idle_pct  = send_pcts[p];
            recv_stall_pct = recv_pcts[p];
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                pick_random_op(op, id, w, frac);
                offer_beat(op, id, w, frac);
                res = apply_selector_op(op, id, w, frac);
                expected_results = {expected_results, res};
            end
        end
        s_axis_tvalid <= 1'b0;

        // Drain outstanding results, then watch for stray beats
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #TIMEOUT_NS;
        $display("status: fail");
        $finish;
    end

endmodule
